### src/bfd_pkg.sv
// Shared types and constants for the bracket frame deframer.
package bfd_pkg;

    // Header layout: id, length, 4-byte timestamp, 2-byte checksum
    localparam int HEADER_BYTES = 8;
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

    // Framing marks
    localparam logic [7:0] START_MARK = 8'h5B;  // '['
    localparam logic [7:0] END_MARK   = 8'h5D;  // ']'

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_DONE      = 2'd1,
        KIND_TOO_LONG  = 2'd2,
        KIND_BAD_TRAIL = 2'd3
    } t_kind;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT0  = 5'b00001,
        PH_HUNT1  = 5'b00010,
        PH_HEADER = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_TRAIL  = 5'b10000
    } t_phase;

    typedef logic [HEADER_BYTES-1:0][7:0] t_hdr_bytes;

    // One result transaction as it travels through the queue
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  pay_byte;
        logic [7:0]  pay_index;
        logic [7:0]  id;
        logic [7:0]  len;
        logic [31:0] tstamp;
        logic [15:0] csum;
        logic        frame_end;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

### src/bfd_parser.sv
// Front end: accepts received bytes, runs the framing state machine, builds results.
module bfd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output logic              o_push,
    output bfd_pkg::t_result  o_result
);
    import bfd_pkg::*;

    t_phase                r_phase,     n_phase;
    logic [HDR_CNT_W-1:0]  r_hdr_cnt,   n_hdr_cnt;
    t_hdr_bytes            r_hdr,       n_hdr;
    logic [7:0]            r_pay_cnt,   n_pay_cnt;
    logic                  r_trail_one, n_trail_one;
    logic [7:0]            r_max;
    t_kind                 res_kind;
    logic [7:0]            res_byte;
    logic [7:0]            res_index;

    // Max payload length register, always writable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 8'hFF;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    // Framing state machine
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr       = r_hdr;
        n_pay_cnt   = r_pay_cnt;
        n_trail_one = r_trail_one;
        o_push      = 1'b0;
        res_kind    = KIND_PAYLOAD;
        res_byte    = 8'd0;
        res_index   = 8'd0;
        if (i_accept) begin
            case (r_phase)
                PH_HUNT1: begin
                    if (i_rx_byte == START_MARK) begin
                        n_hdr_cnt = '0;
                        n_phase   = PH_HEADER;
                    end else begin
                        n_phase = PH_HUNT0;
                    end
                end
                PH_HEADER: begin
                    n_hdr[r_hdr_cnt] = i_rx_byte;
                    n_hdr_cnt        = r_hdr_cnt + 1'b1;
                    if (r_hdr_cnt == HDR_LAST) begin
                        if (n_hdr[1] > r_max) begin
                            // frame too long: drop right after header
                            n_phase  = PH_HUNT0;
                            o_push   = 1'b1;
                            res_kind = KIND_TOO_LONG;
                        end else begin
                            n_pay_cnt   = 8'd0;
                            n_trail_one = 1'b0;
                            n_phase     = (n_hdr[1] == 8'd0) ? PH_TRAIL : PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_pay_cnt = r_pay_cnt + 8'd1;
                    if (n_pay_cnt == r_hdr[1]) begin
                        n_trail_one = 1'b0;
                        n_phase     = PH_TRAIL;
                    end
                    o_push    = 1'b1;
                    res_kind  = KIND_PAYLOAD;
                    res_byte  = i_rx_byte;
                    res_index = r_pay_cnt;
                end
                PH_TRAIL: begin
                    if (i_rx_byte != END_MARK) begin
                        n_phase  = PH_HUNT0;
                        o_push   = 1'b1;
                        res_kind = KIND_BAD_TRAIL;
                    end else if (!r_trail_one) begin
                        n_trail_one = 1'b1;
                    end else begin
                        n_phase  = PH_HUNT0;
                        o_push   = 1'b1;
                        res_kind = KIND_DONE;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == START_MARK) ? PH_HUNT1 : PH_HUNT0;
                end
            endcase
        end
    end

    // Result assembly; header taken with this cycle's write applied
    always_comb begin
        o_result.kind      = res_kind;
        o_result.pay_byte  = res_byte;
        o_result.pay_index = res_index;
        o_result.id        = n_hdr[0];
        o_result.len       = n_hdr[1];
        o_result.tstamp    = {n_hdr[5], n_hdr[4], n_hdr[3], n_hdr[2]};
        o_result.csum      = {n_hdr[7], n_hdr[6]};
        o_result.frame_end = (res_kind != KIND_PAYLOAD);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT0;
            r_hdr_cnt   <= '0;
            r_pay_cnt   <= 8'd0;
            r_trail_one <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_pay_cnt   <= n_pay_cnt;
            r_trail_one <= n_trail_one;
        end
    end

    // Header bytes, no reset needed
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

### src/bfd_queue.sv
// Small result queue between parser and output stage.
module bfd_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/bfd_out_stage.sv
// Back end: output register that drains the result queue.
module bfd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  bfd_pkg::t_result  i_q_data,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bfd_pkg::t_result  o_out_data
);
    import bfd_pkg::*;

    logic    r_valid;
    t_result r_data;

    // Load when empty or when the current transaction is taken
    assign o_q_pop     = i_q_valid && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= i_q_data;
        end
    end

endmodule

### src/bracket_frame_deframer_top.sv
// Top level of the bracket frame deframer: parser, result queue, output stage.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_data (max payload length)
//  in       | i_in_valid  / o_in_ready   | i_rx_byte
//  out      | o_out_valid / i_out_ready  | o_result_kind .. o_frame_end
//
// One byte is accepted per cycle while the result queue is not full; the parser updates its state in that cycle.
// A result passes from the parser through the result queue into the output register.
// Input stalls only when the result queue is full, i.e. QUEUE_DEPTH results wait
// behind the one held in the output register. Reset is synchronous, active low; the
// max payload length resets to 255 and configuration writes are always taken.
module bracket_frame_deframer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_payload_index,
    output logic [7:0]  o_frame_id,
    output logic [7:0]  o_frame_length,
    output logic [31:0] o_frame_timestamp,
    output logic [15:0] o_wire_checksum,
    output logic        o_frame_end
);
    import bfd_pkg::*;

    logic                accept;
    logic                push;
    t_result             parse_res;
    logic                q_full;
    logic                q_valid;
    logic [RESULT_W-1:0] q_data;
    logic                q_pop;
    t_result             out_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign accept      = i_in_valid && o_in_ready;

    // Front end
    bfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_push      (push),
        .o_result    (parse_res)
    );

    // Decoupling queue
    bfd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (RESULT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (parse_res),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Back end
    bfd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (t_result'(q_data)),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (out_res)
    );

    assign o_result_kind     = out_res.kind;
    assign o_payload_byte    = out_res.pay_byte;
    assign o_payload_index   = out_res.pay_index;
    assign o_frame_id        = out_res.id;
    assign o_frame_length    = out_res.len;
    assign o_frame_timestamp = out_res.tstamp;
    assign o_wire_checksum   = out_res.csum;
    assign o_frame_end       = out_res.frame_end;

endmodule
